// ===== design/coas_pkg.sv =====
// shared constants, codes and the arctangent table of the cone avoidance steering block
package coas_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
    localparam int CW           = 36;
    localparam int ZW           = 32;
    localparam int ISQ_W        = 58;
    localparam int ISQ_STAGES   = ISQ_W / 2;
    localparam int DEG_A        = 1048576;

    localparam logic [2:0] REG_TARGET_EAST  = 3'd0;
    localparam logic [2:0] REG_TARGET_NORTH = 3'd1;
    localparam logic [2:0] REG_INNER_RADIUS = 3'd2;
    localparam logic [2:0] REG_OUTER_RADIUS = 3'd3;
    localparam logic [2:0] REG_TRACK_GAIN   = 3'd4;
    localparam logic [2:0] REG_SPEED_LIMIT  = 3'd5;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_CONE  = 2'd1;
    localparam logic [1:0] MODE_BRAKE = 2'd2;

    function automatic logic signed [ZW-1:0] atan_a(input int idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            0:  v = 32'sd47185920;
            1:  v = 32'sd27855475;
            2:  v = 32'sd14718068;
            3:  v = 32'sd7471121;
            4:  v = 32'sd3750058;
            5:  v = 32'sd1876857;
            6:  v = 32'sd938658;
            7:  v = 32'sd469357;
            8:  v = 32'sd234682;
            9:  v = 32'sd117342;
            10: v = 32'sd58671;
            11: v = 32'sd29335;
            12: v = 32'sd14668;
            13: v = 32'sd7334;
            14: v = 32'sd3667;
            15: v = 32'sd1833;
            16: v = 32'sd917;
            17: v = 32'sd458;
            18: v = 32'sd229;
            19: v = 32'sd115;
            20: v = 32'sd57;
            21: v = 32'sd29;
            22: v = 32'sd14;
            23: v = 32'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/coas_isqrt.sv =====
// pipelined integer square root, one result bit per stage
module coas_isqrt
    import coas_pkg::*;
(
    input  logic                  aclk,
    input  logic                  en,
    input  logic [ISQ_W-1:0]      val,
    output logic [ISQ_STAGES-1:0] root
);

    logic [ISQ_W-1:0] rem_reg  [0:ISQ_STAGES-1];
    logic [ISQ_W-1:0] res_reg  [0:ISQ_STAGES-1];
    logic [ISQ_W-1:0] rem_next [0:ISQ_STAGES-1];
    logic [ISQ_W-1:0] res_next [0:ISQ_STAGES-1];

    for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_stage
        logic [ISQ_W-1:0] rem_in, res_in, trial, bitv;
        if (k == 0) begin : g_first
            assign rem_in = val;
            assign res_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
        end
        assign bitv  = ISQ_W'(1) << (ISQ_W - 2 - 2 * k);
        assign trial = res_in + bitv;
        always_comb begin
            if (rem_in >= trial) begin
                rem_next[k] = rem_in - trial;
                res_next[k] = (res_in >> 1) + bitv;
            end else begin
                rem_next[k] = rem_in;
                res_next[k] = res_in >> 1;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next[k];
                res_reg[k] <= res_next[k];
            end
        end
    end

    assign root = res_reg[ISQ_STAGES-1][ISQ_STAGES-1:0];

endmodule

// ===== design/coas_cordic.sv =====
// pipelined cordic, vectoring or rotation, one micro-rotation per stage
module coas_cordic
    import coas_pkg::*;
(
    input  logic                 aclk,
    input  logic                 en,
    input  logic                 rotate,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [ZW-1:0] z_out
);

    logic signed [CW-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg [0:CORDIC_STEPS];
    logic                 zero_reg [0:CORDIC_STEPS];
    logic                 negx_reg [0:CORDIC_STEPS];

    logic signed [CW-1:0] x_next, y_next;
    logic signed [ZW-1:0] z_next;
    logic                 zero_next, negx_next;

    // vectoring: zero y gives 0 or a half turn, negative x is turned a half turn first
    always_comb begin
        x_next    = x_in;
        y_next    = y_in;
        z_next    = z_in;
        zero_next = 1'b0;
        negx_next = 1'b0;
        if (!rotate) begin
            if (y_in == '0) begin
                zero_next = 1'b1;
                negx_next = x_in[CW-1];
            end else if (x_in[CW-1]) begin
                x_next = -x_in;
                y_next = -y_in;
                z_next = ZW'(180 * DEG_A);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            zero_reg[0] <= zero_next;
            negx_reg[0] <= negx_next;
        end
    end

    for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_stage
        logic signed [CW-1:0] xs, ys, xn, yn;
        logic signed [ZW-1:0] zn;
        logic                 up;
        assign xs = x_reg[k-1] >>> (k - 1);
        assign ys = y_reg[k-1] >>> (k - 1);
        assign up = rotate ? z_reg[k-1][ZW-1] : !y_reg[k-1][CW-1];
        always_comb begin
            if (up) begin
                xn = x_reg[k-1] + ys;
                yn = y_reg[k-1] - xs;
                zn = z_reg[k-1] + atan_a(k - 1);
            end else begin
                xn = x_reg[k-1] - ys;
                yn = y_reg[k-1] + xs;
                zn = z_reg[k-1] - atan_a(k - 1);
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k]    <= xn;
                y_reg[k]    <= yn;
                z_reg[k]    <= zn;
                zero_reg[k] <= zero_reg[k-1];
                negx_reg[k] <= negx_reg[k-1];
            end
        end
    end

    assign x_out = x_reg[CORDIC_STEPS];
    assign y_out = y_reg[CORDIC_STEPS];
    assign z_out = zero_reg[CORDIC_STEPS]
                 ? (negx_reg[CORDIC_STEPS] ? ZW'(180 * DEG_A) : '0)
                 : z_reg[CORDIC_STEPS];

endmodule

// ===== design/cone_obstacle_avoidance_steer.sv =====
// top level of the cone obstacle avoidance steering pipeline
//
//  channel   dir  fields (lsb first)                                 handshake
//  s_        in   pos_x, pos_y, obstacle_distance, obstacle_bearing  tvalid/tready
//  m_        out  vel_x, vel_y, heading, mode                        tvalid/tready
//  apb       in   six registers at byte address 4*i                  psel/penable
//
//  one word per cycle while the output is not stalled; 2*CORDIC_STEPS + 39 register
//  stages in all, from the two square root pipelines (29 stages), the vectoring and
//  rotation cordics (CORDIC_STEPS + 1 each) and eight stages of setup and rounding.
//  reset clears the valid bits and loads the register defaults.
//  a stalled output word freezes the whole pipeline; nothing is lost or repeated.
module cone_obstacle_avoidance_steer
    import coas_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // pos_x, pos_y, obstacle_distance, obstacle_bearing
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // vel_x, vel_y, heading, mode
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef struct packed {
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic [15:0]        odist;
        logic [8:0]         brg;
    } isq_sb_t;

    typedef struct packed {
        logic [15:0]           odist;
        logic [8:0]            brg;
        logic [ISQ_STAGES-1:0] sroot;
    } vec_sb_t;

    typedef struct packed {
        logic        neg;
        logic [12:0] hd;
        logic [1:0]  mode;
    } rot_sb_t;

    logic [15:0] target_east_reg, target_north_reg, inner_radius_reg, outer_radius_reg;
    logic [15:0] track_gain_reg;
    logic [14:0] speed_limit_reg;

    logic en;
    logic m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_east_reg  <= 16'd700;
            target_north_reg <= 16'd3000;
            inner_radius_reg <= 16'd420;
            outer_radius_reg <= 16'd1400;
            track_gain_reg   <= 16'd2048;
            speed_limit_reg  <= 15'd0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_TARGET_EAST:  target_east_reg  <= pwdata[15:0];
                REG_TARGET_NORTH: target_north_reg <= pwdata[15:0];
                REG_INNER_RADIUS: inner_radius_reg <= pwdata[15:0];
                REG_OUTER_RADIUS: outer_radius_reg <= pwdata[15:0];
                REG_TRACK_GAIN:   track_gain_reg   <= pwdata[15:0];
                REG_SPEED_LIMIT:  speed_limit_reg  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_TARGET_EAST:  prdata = {16'd0, target_east_reg};
            REG_TARGET_NORTH: prdata = {16'd0, target_north_reg};
            REG_INNER_RADIUS: prdata = {16'd0, inner_radius_reg};
            REG_OUTER_RADIUS: prdata = {16'd0, outer_radius_reg};
            REG_TRACK_GAIN:   prdata = {16'd0, track_gain_reg};
            REG_SPEED_LIMIT:  prdata = {17'd0, speed_limit_reg};
            default:          prdata = '0;
        endcase
    end

    function automatic logic [8:0] mod360(input logic [11:0] v);
        logic [11:0] r;
        if (v >= 12'd720) begin
            r = v - 12'd720;
        end else if (v >= 12'd360) begin
            r = v - 12'd360;
        end else begin
            r = v;
        end
        return r[8:0];
    endfunction

    // input register
    logic              v0_reg;
    logic signed [15:0] pos_x_reg, pos_y_reg;
    logic [15:0]       dist0_reg;
    logic [8:0]        brg0_reg;

    // target difference
    logic              v1_reg;
    logic signed [16:0] dx1_reg, dy1_reg;
    logic [15:0]       dist1_reg;
    logic [8:0]        brg1_reg;

    // squares
    logic              v2_reg;
    logic [31:0]       dx2_reg, dy2_reg, dist2_reg, rin2_reg;
    logic signed [16:0] dx2c_reg, dy2c_reg;
    logic [15:0]       dist2c_reg;
    logic [8:0]        brg2_reg;
    logic signed [33:0] dxsq, dysq;

    // sums
    logic              v3_reg;
    logic [32:0]       d2_reg;
    logic [31:0]       diff_reg;
    isq_sb_t           sb3_reg;

    assign dxsq = dx1_reg * dx1_reg;
    assign dysq = dy1_reg * dy1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_x_reg  <= s_tdata[15:0];
            pos_y_reg  <= s_tdata[31:16];
            dist0_reg  <= s_tdata[47:32];
            brg0_reg   <= s_tdata[56:48];
            dx1_reg    <= 17'(signed'(target_east_reg)) - 17'(pos_x_reg);
            dy1_reg    <= 17'(signed'(target_north_reg)) - 17'(pos_y_reg);
            dist1_reg  <= dist0_reg;
            brg1_reg   <= brg0_reg;
            dx2_reg    <= dxsq[31:0];
            dy2_reg    <= dysq[31:0];
            dist2_reg  <= 32'(dist1_reg) * 32'(dist1_reg);
            rin2_reg   <= 32'(inner_radius_reg) * 32'(inner_radius_reg);
            dx2c_reg   <= dx1_reg;
            dy2c_reg   <= dy1_reg;
            dist2c_reg <= dist1_reg;
            brg2_reg   <= brg1_reg;
            d2_reg     <= {1'b0, dx2_reg} + {1'b0, dy2_reg};
            diff_reg   <= dist2_reg - rin2_reg;
            sb3_reg    <= '{dx: dx2c_reg, dy: dy2c_reg, odist: dist2c_reg, brg: brg2_reg};
        end
    end

    // square roots: target distance and cone leg
    logic [ISQ_STAGES-1:0] s_root, o_root;
    logic [ISQ_W-1:0]      s_val, o_val;
    isq_sb_t               isq_sb_reg [0:ISQ_STAGES-1];
    logic [ISQ_STAGES-1:0] isq_vld_reg;

    assign s_val = {1'b0, d2_reg, 24'd0};
    assign o_val = {10'd0, diff_reg, 16'd0};

    coas_isqrt u_isqrt_trk (.aclk(aclk), .en(en), .val(s_val), .root(s_root));
    coas_isqrt u_isqrt_obs (.aclk(aclk), .en(en), .val(o_val), .root(o_root));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            isq_vld_reg <= '0;
        end else if (en) begin
            isq_vld_reg <= {isq_vld_reg[ISQ_STAGES-2:0], v3_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            isq_sb_reg[0] <= sb3_reg;
            for (int k = 1; k < ISQ_STAGES; k++) begin
                isq_sb_reg[k] <= isq_sb_reg[k-1];
            end
        end
    end

    // vectoring: track angle and cone half-angle
    isq_sb_t              isq_o;
    logic signed [CW-1:0] trk_x, trk_y, cone_x, cone_y, vx_unused_a, vy_unused_a;
    logic signed [CW-1:0] vx_unused_b, vy_unused_b;
    logic signed [ZW-1:0] z_trk, z_cone;
    vec_sb_t              vec_sb_reg [0:CORDIC_LAT-1];
    logic [CORDIC_LAT-1:0] vec_vld_reg;

    assign isq_o  = isq_sb_reg[ISQ_STAGES-1];
    assign trk_x  = CW'(isq_o.dx) <<< 12;
    assign trk_y  = CW'(isq_o.dy) <<< 12;
    assign cone_x = {{(CW - ISQ_STAGES){1'b0}}, o_root};
    assign cone_y = {{(CW - 24){1'b0}}, inner_radius_reg, 8'd0};

    coas_cordic u_vec_trk (
        .aclk(aclk), .en(en), .rotate(1'b0),
        .x_in(trk_x), .y_in(trk_y), .z_in('0),
        .x_out(vx_unused_a), .y_out(vy_unused_a), .z_out(z_trk)
    );

    coas_cordic u_vec_cone (
        .aclk(aclk), .en(en), .rotate(1'b0),
        .x_in(cone_x), .y_in(cone_y), .z_in('0),
        .x_out(vx_unused_b), .y_out(vy_unused_b), .z_out(z_cone)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vec_vld_reg <= '0;
        end else if (en) begin
            vec_vld_reg <= {vec_vld_reg[CORDIC_LAT-2:0], isq_vld_reg[ISQ_STAGES-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_sb_reg[0] <= '{odist: isq_o.odist, brg: isq_o.brg, sroot: s_root};
            for (int k = 1; k < CORDIC_LAT; k++) begin
                vec_sb_reg[k] <= vec_sb_reg[k-1];
            end
        end
    end

    // stage e: track heading, clamped half-angle, speed product
    vec_sb_t              vec_o;
    logic signed [ZW-1:0] hd_sum, hd_raw, hd_wrap;
    logic                 ve_reg;
    logic [12:0]          hd_e_reg;
    logic [ZW-1:0]        ta_e_reg;
    logic [44:0]          prod_e_reg;
    logic [15:0]          dist_e_reg;
    logic [8:0]           brg_e_reg;

    assign vec_o   = vec_sb_reg[CORDIC_LAT-1];
    assign hd_sum  = z_trk + ZW'(32768);
    assign hd_raw  = hd_sum >>> 16;
    assign hd_wrap = hd_raw[ZW-1] ? hd_raw + ZW'(5760) : hd_raw;

    always_ff @(posedge aclk) begin
        if (en) begin
            hd_e_reg   <= hd_wrap[12:0];
            ta_e_reg   <= z_cone[ZW-1] ? '0 : z_cone;
            prod_e_reg <= 45'(track_gain_reg) * 45'(vec_o.sroot);
            dist_e_reg <= vec_o.odist;
            brg_e_reg  <= vec_o.brg;
        end
    end

    // stage f: mode and final heading, saturated speed
    logic [45:0] rsum;
    logic [21:0] speed_full;
    logic [14:0] speed_f_next;
    logic [8:0]  trk_deg, shift, h_deg;
    logic [9:0]  gap;
    logic [32:0] csum;
    logic [11:0] ceil_t, floor_t, shift_sum;
    logic        in_cone;
    logic [1:0]  mode_f_next;
    logic [12:0] hd_f_next;

    logic        vf_reg;
    logic [14:0] speed_f_reg;
    logic [12:0] hd_f_reg;
    logic [1:0]  mode_f_reg;

    assign rsum       = {1'b0, prod_e_reg} + 46'(1 << 23);
    assign speed_full = rsum[45:24];
    assign trk_deg    = hd_e_reg[12:4];
    assign csum       = {1'b0, ta_e_reg} + 33'(DEG_A - 1);
    assign ceil_t     = csum[31:20];
    assign floor_t    = ta_e_reg[31:20];

    always_comb begin
        speed_f_next = (speed_full > 22'(speed_limit_reg)) ? speed_limit_reg
                                                           : speed_full[14:0];
        gap = (brg_e_reg >= 9'd360) ? 10'(brg_e_reg) - 10'd360 : 10'd360 - 10'(brg_e_reg);
        in_cone = ({2'b0, gap, 20'd0} < ta_e_reg) || ({3'b0, brg_e_reg, 20'd0} < ta_e_reg);
        if (brg_e_reg < 9'd180) begin
            shift_sum = 12'(brg_e_reg) + 12'd720 - ceil_t;
        end else begin
            shift_sum = 12'(brg_e_reg) + floor_t;
        end
        shift = mod360(shift_sum);
        h_deg = mod360(12'(trk_deg) + 12'(shift));
        priority if (inner_radius_reg > dist_e_reg) begin
            mode_f_next = MODE_BRAKE;
            hd_f_next   = {mod360(12'(trk_deg) + 12'(brg_e_reg) + 12'd180), 4'd0};
        end else if (in_cone && (dist_e_reg < outer_radius_reg)) begin
            mode_f_next = MODE_CONE;
            hd_f_next   = {h_deg, 4'd0};
        end else begin
            mode_f_next = MODE_CLEAR;
            hd_f_next   = hd_e_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            speed_f_reg <= speed_f_next;
            hd_f_reg    <= hd_f_next;
            mode_f_reg  <= mode_f_next;
        end
    end

    // stage g: scaled speed and folded angle
    logic                 vg_reg;
    logic signed [CW-1:0] xg_reg;
    logic signed [ZW-1:0] zg_reg, z_full;
    rot_sb_t              sbg_reg;

    assign z_full = ZW'(hd_f_reg) <<< 16;

    always_ff @(posedge aclk) begin
        if (en) begin
            xg_reg <= CW'(31'(speed_f_reg) * 31'd39797);
            if (hd_f_reg >= 13'd4320) begin
                zg_reg  <= z_full - ZW'(360 * DEG_A);
                sbg_reg <= '{neg: 1'b0, hd: hd_f_reg, mode: mode_f_reg};
            end else if (hd_f_reg > 13'd1440) begin
                zg_reg  <= z_full - ZW'(180 * DEG_A);
                sbg_reg <= '{neg: 1'b1, hd: hd_f_reg, mode: mode_f_reg};
            end else begin
                zg_reg  <= z_full;
                sbg_reg <= '{neg: 1'b0, hd: hd_f_reg, mode: mode_f_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
        end else if (en) begin
            ve_reg <= vec_vld_reg[CORDIC_LAT-1];
            vf_reg <= ve_reg;
            vg_reg <= vf_reg;
        end
    end

    // rotation to velocity
    logic signed [CW-1:0] x_rot, y_rot;
    logic signed [ZW-1:0] z_unused;
    rot_sb_t              rot_sb_reg [0:CORDIC_LAT-1];
    logic [CORDIC_LAT-1:0] rot_vld_reg;

    coas_cordic u_rot (
        .aclk(aclk), .en(en), .rotate(1'b1),
        .x_in(xg_reg), .y_in('0), .z_in(zg_reg),
        .x_out(x_rot), .y_out(y_rot), .z_out(z_unused)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_vld_reg <= '0;
        end else if (en) begin
            rot_vld_reg <= {rot_vld_reg[CORDIC_LAT-2:0], vg_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rot_sb_reg[0] <= sbg_reg;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                rot_sb_reg[k] <= rot_sb_reg[k-1];
            end
        end
    end

    // output rounding and saturation
    rot_sb_t              rot_o;
    logic signed [CW-1:0] xr, yr, xn, yn;
    logic signed [15:0]   vel_x, vel_y;

    assign rot_o = rot_sb_reg[CORDIC_LAT-1];
    assign xr    = (x_rot + CW'(32768)) >>> 16;
    assign yr    = (y_rot + CW'(32768)) >>> 16;
    assign xn    = rot_o.neg ? -xr : xr;
    assign yn    = rot_o.neg ? -yr : yr;

    always_comb begin
        if (xn > CW'(32767)) begin
            vel_x = 16'sd32767;
        end else if (xn < -CW'(32767)) begin
            vel_x = -16'sd32767;
        end else begin
            vel_x = xn[15:0];
        end
        if (yn > CW'(32767)) begin
            vel_y = 16'sd32767;
        end else if (yn < -CW'(32767)) begin
            vel_y = -16'sd32767;
        end else begin
            vel_y = yn[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= rot_vld_reg[CORDIC_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {1'b0, rot_o.mode, rot_o.hd, vel_y, vel_x};
        end
    end

endmodule
